FILE: src/arpc_pkg.sv
// shared types and constants for the arp cache learn and age block
package arpc_pkg;

   localparam int ARPC_TABLE_DEPTH = 16;
   localparam int QUEUE_DEPTH = 2; // power of two

   localparam logic [15:0] ARP_FRAME_TYPE = 16'h0806;
   localparam logic [7:0] LIFETIME_RESET = 8'd10;
   localparam logic [15:0] MIN_LEN_RESET = 16'd20;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIFETIME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAME_LENGTH = 1'b1;

   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_REFRESHED = 3'd1;
   localparam logic [2:0] ST_ADDED = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_TICK = 3'd4;

   typedef enum logic [1:0] {
      OP_IGNORE,
      OP_LOOKUP,
      OP_TICK
   } arpc_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_AGE
   } arpc_state_type;

   typedef struct packed {
      logic        command;
      logic [15:0] frame_length;
      logic [15:0] frame_type;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
   } arpc_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] entries_held;
      logic [3:0] slot_touched;
   } arpc_rsp_type;

   typedef struct packed {
      arpc_op_type op;
      logic [47:0] mac;
      logic [31:0] ip;
   } arpc_work_type;

endpackage

FILE: src/arpc_front.sv
// front stage: accepts items, classifies them and holds one for the queue
module arpc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  arpc_pkg::arpc_req_type  req_data,
   input  logic [15:0]             min_frame_length,
   output logic                    push_valid,
   input  logic                    push_ready,
   output arpc_pkg::arpc_work_type push_item
);
   import arpc_pkg::*;

   logic          valid_ff, valid_in;
   arpc_work_type work_ff, work_in;
   arpc_op_type   op;
   logic          accept;

   always_comb begin
      if (req_data.command) begin
         op = OP_TICK;
      end else if (req_data.frame_length == 16'd0 ||
                   req_data.frame_length < min_frame_length ||
                   req_data.frame_type != ARP_FRAME_TYPE) begin
         op = OP_IGNORE;
      end else begin
         op = OP_LOOKUP;
      end
   end

   assign req_ready = !valid_ff || push_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      work_in = work_ff;
      valid_in = valid_ff && !push_ready;
      if (accept) begin
         valid_in = 1'b1;
         work_in.op = op;
         work_in.mac = req_data.sender_mac;
         work_in.ip = req_data.sender_ip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign push_valid = valid_ff;
   assign push_item = work_ff;

endmodule

FILE: src/arpc_queue.sv
// short queue of classified items between front and back
module arpc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  arpc_pkg::arpc_work_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output arpc_pkg::arpc_work_type pop_item
);
   import arpc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   arpc_work_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/arpc_back.sv
// back end: table memory, search and aging walks, result register
module arpc_back #(
   parameter int TABLE_DEPTH = arpc_pkg::ARPC_TABLE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  arpc_pkg::arpc_work_type pop_item,
   input  logic [7:0]              entry_lifetime,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output arpc_pkg::arpc_rsp_type  rsp_data
);
   import arpc_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [47:0] mac_mem [TABLE_DEPTH];
   logic [31:0] ip_mem [TABLE_DEPTH];
   logic [7:0]  life_mem [TABLE_DEPTH];

   arpc_state_type state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic              pend_ff;
   logic [ADDR_W-1:0] tag_ff;
   logic [47:0]       mac_q_ff, cur_mac_ff;
   logic [31:0]       ip_q_ff, cur_ip_ff;
   logic [7:0]        life_q_ff;
   logic              rsp_valid_ff;
   arpc_rsp_type      rsp_ff, rsp_in;

   logic              pop, rd_en, match, last, empty, full, keep, done, rsp_load;
   logic              we_all, we_life;
   logic [ADDR_W-1:0] waddr;
   logic [47:0]       wmac;
   logic [31:0]       wip;
   logic [7:0]        wlife, aged_life;
   logic [CNT_W-1:0]  fill_inc;
   logic [31:0]       fill_wide, inc_wide, tag_wide;

   assign pop = pop_valid && pop_ready;
   assign match = pend_ff && (mac_q_ff == cur_mac_ff || ip_q_ff == cur_ip_ff);
   assign last = pend_ff && (CNT_W'(tag_ff) == fill_ff - CNT_W'(1));
   assign empty = fill_ff == '0;
   assign full = fill_ff == CNT_W'(TABLE_DEPTH);
   assign fill_inc = fill_ff + CNT_W'(1);
   assign aged_life = (life_q_ff == 8'd0) ? 8'd0 : life_q_ff - 8'd1;
   assign fill_wide = 32'(fill_ff);
   assign inc_wide = 32'(fill_inc);
   assign tag_wide = 32'(tag_ff);
   assign done = (state_ff == S_SEARCH && (match || empty || last)) ||
                 (state_ff == S_AGE && (empty || last));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop && pop_item.op == OP_LOOKUP) begin
               state_in = S_SEARCH;
            end else if (pop && pop_item.op == OP_TICK) begin
               state_in = S_AGE;
            end
         end
         S_SEARCH, S_AGE: begin
            if (done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      rd_en = 1'b0;
      keep = 1'b0;
      we_all = 1'b0;
      we_life = 1'b0;
      waddr = '0;
      wmac = cur_mac_ff;
      wip = cur_ip_ff;
      wlife = entry_lifetime;
      fill_in = fill_ff;
      wr_in = wr_ff;
      rsp_load = 1'b0;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            pop_ready = !rsp_valid_ff;
            if (pop && pop_item.op == OP_IGNORE) begin
               rsp_load = 1'b1;
               rsp_in.status = ST_IGNORED;
               rsp_in.entries_held = fill_wide[4:0];
               rsp_in.slot_touched = 4'd0;
            end
         end
         S_SEARCH: begin
            rd_en = ptr_ff < fill_ff;
            if (match) begin
               we_life = 1'b1;
               waddr = tag_ff;
               rsp_load = 1'b1;
               rsp_in.status = ST_REFRESHED;
               rsp_in.entries_held = fill_wide[4:0];
               rsp_in.slot_touched = tag_wide[3:0];
            end else if (empty || last) begin
               rsp_load = 1'b1;
               if (full) begin
                  rsp_in.status = ST_FULL;
                  rsp_in.entries_held = fill_wide[4:0];
                  rsp_in.slot_touched = 4'd0;
               end else begin
                  we_all = 1'b1;
                  we_life = 1'b1;
                  waddr = fill_ff[ADDR_W-1:0];
                  fill_in = fill_inc;
                  rsp_in.status = ST_ADDED;
                  rsp_in.entries_held = inc_wide[4:0];
                  rsp_in.slot_touched = fill_wide[3:0];
               end
            end
         end
         S_AGE: begin
            rd_en = ptr_ff < fill_ff;
            keep = pend_ff && life_q_ff != 8'd1;
            if (keep) begin
               we_all = 1'b1;
               we_life = 1'b1;
               waddr = wr_ff[ADDR_W-1:0];
               wmac = mac_q_ff;
               wip = ip_q_ff;
               wlife = aged_life;
            end
            wr_in = wr_ff + CNT_W'(keep);
            if (empty || last) begin
               fill_in = wr_in;
               rsp_load = 1'b1;
               rsp_in.status = ST_TICK;
               rsp_in.entries_held = fill_wide[4:0];
               rsp_in.slot_touched = 4'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         ptr_ff <= '0;
         wr_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         pend_ff <= rd_en;
         if (pop) begin
            ptr_ff <= '0;
            wr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + CNT_W'(rd_en);
            wr_ff <= wr_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_mac_ff <= pop_item.mac;
         cur_ip_ff <= pop_item.ip;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we_all) begin
         mac_mem[waddr] <= wmac;
         ip_mem[waddr] <= wip;
      end
      if (we_life) begin
         life_mem[waddr] <= wlife;
      end
      if (rd_en) begin
         mac_q_ff <= mac_mem[ptr_ff[ADDR_W-1:0]];
         ip_q_ff <= ip_mem[ptr_ff[ADDR_W-1:0]];
         life_q_ff <= life_mem[ptr_ff[ADDR_W-1:0]];
         tag_ff <= ptr_ff[ADDR_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: src/arp_cache_learn_and_age_top.sv
// top level of the arp cache with learning and lifetime aging
//
//   port group   direction   handshake          payload
//   req_*        in          req_valid/ready    arpc_req_type
//   rsp_*        out         rsp_valid/ready    arpc_rsp_type
//   csr_*        in          csr_we             csr_index, csr_wdata
//
// an item passes through the front register and the queue; the back end
// registers the result of an ignored frame as it takes the item, and for a
// lookup or a tick walks the table memory one entry a cycle on its read port
// reset does not clear the table memory, only the fill count
// a waiting result holds the back end; the front keeps taking items until the
// queue and its register are full
module arp_cache_learn_and_age_top #(
   parameter int TABLE_DEPTH = arpc_pkg::ARPC_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  arpc_pkg::arpc_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output arpc_pkg::arpc_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import arpc_pkg::*;

   logic [7:0]    lifetime_ff;
   logic [15:0]   min_len_ff;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   arpc_work_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
         min_len_ff <= MIN_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_LIFETIME: lifetime_ff <= csr_wdata[7:0];
            CSR_MIN_FRAME_LENGTH: min_len_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   arpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .min_frame_length (min_len_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   arpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   arpc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .entry_lifetime (lifetime_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_IGNORED || rsp_data.status == ST_REFRESHED ||
                     rsp_data.status == ST_ADDED || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_TICK))
      else $error("result status out of range");

   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_IGNORED || rsp_data.status == ST_FULL ||
                    rsp_data.status == ST_TICK) |-> rsp_data.slot_touched == 4'd0)
      else $error("slot reported for an item that touched none");

   a_added_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ADDED |->
         rsp_data.entries_held[3:0] == rsp_data.slot_touched + 4'd1)
      else $error("added slot does not match new fill");

endmodule
